@@ rtl/svts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svts_pkg
// Shared codes and types of the single-voice tone sequencer.
// ----------------------------------------------------------------------------
package svts_pkg;

    localparam int REQ_W    = 3;
    localparam int NOTE_W   = 7;
    localparam int HOLD_W   = 8;
    localparam int BEEP_W   = 16;
    localparam int COUNT_W  = 9;
    localparam int INDEX_W  = 8;
    localparam int ACTION_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BEEP  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PLAY  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_STOP  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INIT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd5;

    // voice action codes
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ON   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_OFF  = 2'd2;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [HOLD_W-1:0] ticks;
    } song_entry_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [NOTE_W-1:0]   note;
        logic                playing;
    } voice_result_t;

endpackage

@@ rtl/single_voice_tone_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_voice_tone_sequencer_unit
// Single-voice note sequencer with a writable song table and one-shot beep.
// ----------------------------------------------------------------------------
// Each request (tick, beep, play, stop, init, song entry write) is one input
// transaction and yields exactly one result transaction carrying the voice
// action, the note and the playing flag. One request is accepted per clock
// cycle; a result is registered in the output register and waits there while
// the consumer stalls, with the input stalled only when that register is full
// and not draining. The song table is a SONG_DEPTH x 15 bit memory with a
// registered read port; the entry that the next tick would sound is prefetched
// every cycle, so a tick finds that entry already read. Table entries are not
// cleared by reset and must be written before they are played.
// ----------------------------------------------------------------------------
module single_voice_tone_sequencer_unit #(
    parameter int SONG_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [svts_pkg::REQ_W-1:0]          req_type,
    input  logic [svts_pkg::NOTE_W-1:0]         beep_note,
    input  logic [svts_pkg::BEEP_W-1:0]         beep_ticks,
    input  logic [svts_pkg::COUNT_W-1:0]        song_count,
    input  logic [svts_pkg::INDEX_W-1:0]        entry_index,
    input  logic [svts_pkg::NOTE_W-1:0]         entry_note,
    input  logic [svts_pkg::HOLD_W-1:0]         entry_ticks,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [svts_pkg::ACTION_W-1:0]       voice_action,
    output logic [svts_pkg::NOTE_W-1:0]         voice_note,
    output logic                                is_playing
);
    import svts_pkg::*;

    localparam int IDX_W = $clog2(SONG_DEPTH);
    localparam int LEN_W = $clog2(SONG_DEPTH + 1);

    logic          accept;
    logic          wr_en;
    logic [31:0]   index_ext;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    song_entry_t   wr_data;
    song_entry_t   next_entry;
    voice_result_t result;
    voice_result_t held;

    assign accept = in_valid && !in_stall;

    // table write, slots beyond the depth are dropped
    assign index_ext    = 32'(entry_index);
    assign wr_en        = accept && (req_type == REQ_WRITE) &&
                          (index_ext < 32'(SONG_DEPTH));
    assign wr_addr      = index_ext[IDX_W-1:0];
    assign wr_data.note  = entry_note;
    assign wr_data.ticks = entry_ticks;

    svts_song_mem #(
        .SONG_DEPTH (SONG_DEPTH),
        .IDX_W      (IDX_W)
    ) u_song_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (next_entry)
    );

    // sequencer state, one update per accepted request
    svts_seq_ctrl #(
        .SONG_DEPTH (SONG_DEPTH),
        .IDX_W      (IDX_W),
        .LEN_W      (LEN_W)
    ) u_seq_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .beep_note  (beep_note),
        .beep_ticks (beep_ticks),
        .song_count (song_count),
        .next_entry (next_entry),
        .rd_addr    (rd_addr),
        .result     (result)
    );

    svts_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .busy      (in_stall),
        .held      (held)
    );

    assign voice_action = held.action;
    assign voice_note   = held.note;
    assign is_playing   = held.playing;

endmodule

@@ rtl/svts_song_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svts_song_mem
// Song table with one write port and a registered read port that forwards
// a same-cycle write to the read address.
// ----------------------------------------------------------------------------
module svts_song_mem #(
    parameter int SONG_DEPTH = 256,
    parameter int IDX_W      = $clog2(SONG_DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_addr,
    input  svts_pkg::song_entry_t     wr_data,
    input  logic [IDX_W-1:0]          rd_addr,
    output svts_pkg::song_entry_t     rd_data
);
    import svts_pkg::*;

    song_entry_t mem [SONG_DEPTH];
    song_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data always reflects the entry after any write at this edge
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/svts_seq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svts_seq_ctrl
// Sequencer state and per-request update; produces one voice result for
// each accepted request and the prefetch address of the next song entry.
// ----------------------------------------------------------------------------
module svts_seq_ctrl #(
    parameter int SONG_DEPTH = 256,
    parameter int IDX_W      = $clog2(SONG_DEPTH),
    parameter int LEN_W      = $clog2(SONG_DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [svts_pkg::REQ_W-1:0]        req_type,
    input  logic [svts_pkg::NOTE_W-1:0]       beep_note,
    input  logic [svts_pkg::BEEP_W-1:0]       beep_ticks,
    input  logic [svts_pkg::COUNT_W-1:0]      song_count,
    input  svts_pkg::song_entry_t             next_entry,
    output logic [IDX_W-1:0]                  rd_addr,
    output svts_pkg::voice_result_t           result
);
    import svts_pkg::*;

    logic [LEN_W-1:0]  len_reg,  len_next;
    logic [IDX_W-1:0]  pos_reg,  pos_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              play_reg, play_next;
    logic [BEEP_W-1:0] beep_reg, beep_next;
    logic [LEN_W-1:0]  sat_len;

    // position after pos in a loop of len entries
    function automatic logic [IDX_W-1:0] step_pos(input logic [IDX_W-1:0] pos,
                                                  input logic [LEN_W-1:0] len);
        logic [31:0] inc;
        inc = 32'(pos) + 32'd1;
        if (inc >= 32'(len))
        begin
            return '0;
        end
        return inc[IDX_W-1:0];
    endfunction

    always_comb
    begin
        logic [31:0] cnt_ext;
        cnt_ext = 32'(song_count);
        if (cnt_ext > 32'(SONG_DEPTH))
        begin
            sat_len = LEN_W'(SONG_DEPTH);
        end
        else
        begin
            sat_len = cnt_ext[LEN_W-1:0];
        end
    end

    always_comb
    begin
        len_next       = len_reg;
        pos_next       = pos_reg;
        hold_next      = hold_reg;
        play_next      = play_reg;
        beep_next      = beep_reg;
        result.action  = ACT_NONE;
        result.note    = '0;
        if (accept)
        begin
            case (req_type)
                REQ_TICK:
                begin
                    if (beep_reg != '0)
                    begin
                        beep_next = beep_reg - BEEP_W'(1);
                        if (beep_reg == BEEP_W'(1))
                        begin
                            result.action = ACT_OFF;
                            hold_next     = '0;
                        end
                    end
                    else if (play_reg)
                    begin
                        if (hold_reg != '0)
                        begin
                            hold_next = hold_reg - HOLD_W'(1);
                        end
                        else
                        begin
                            // next_entry already holds the entry at the new position
                            pos_next  = step_pos(pos_reg, len_reg);
                            hold_next = next_entry.ticks;
                            if (next_entry.note != '0)
                            begin
                                result.action = ACT_ON;
                                result.note   = next_entry.note;
                            end
                            else
                            begin
                                result.action = ACT_OFF;
                            end
                        end
                    end
                end
                REQ_BEEP:
                begin
                    beep_next     = (beep_ticks == '0) ? BEEP_W'(1) : beep_ticks;
                    result.action = ACT_ON;
                    result.note   = beep_note;
                end
                REQ_PLAY:
                begin
                    if (song_count != '0)
                    begin
                        len_next  = sat_len;
                        pos_next  = IDX_W'(sat_len - LEN_W'(1));
                        hold_next = '0;
                        play_next = 1'b1;
                    end
                end
                REQ_STOP:
                begin
                    play_next = 1'b0;
                    if (beep_reg == '0)
                    begin
                        result.action = ACT_OFF;
                    end
                end
                REQ_INIT:
                begin
                    len_next      = '0;
                    pos_next      = '0;
                    hold_next     = '0;
                    play_next     = 1'b0;
                    beep_next     = '0;
                    result.action = ACT_OFF;
                end
                default:
                begin
                    // table writes are handled by the song memory
                end
            endcase
        end
        result.playing = play_next;
    end

    // prefetch the entry that the next step would sound
    assign rd_addr = step_pos(pos_next, len_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            pos_reg  <= '0;
            hold_reg <= '0;
            play_reg <= 1'b0;
            beep_reg <= '0;
        end
        else
        begin
            len_reg  <= len_next;
            pos_reg  <= pos_next;
            hold_reg <= hold_next;
            play_reg <= play_next;
            beep_reg <= beep_next;
        end
    end

endmodule

@@ rtl/svts_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svts_out_stage
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module svts_out_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  svts_pkg::voice_result_t   result,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic                      busy,
    output svts_pkg::voice_result_t   held
);
    import svts_pkg::*;

    logic          valid_reg;
    voice_result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    // a new transaction may enter whenever the register is empty or the held one leaves this cycle
    assign busy      = valid_reg && out_stall;
    assign held      = result_reg;

endmodule
